// File: src/lsd_pkg.sv
// lsd_pkg: shared widths, command codes, word and control types for the
// layer stack damage scheduler. No dependencies.
package lsd_pkg;

  localparam int ACT_W    = 3;
  localparam int ID_W     = 4;
  localparam int HREQ_W   = 5;
  localparam int COORD_W  = 12;
  localparam int SIZE_W   = 11;
  localparam int KEY_W    = 8;
  localparam int AREA_W   = 14;
  localparam int CFG_IDX_W = 2;
  localparam int MAX_RESULTS = 32;
  localparam int NRES_W   = 6;

  localparam logic [ACT_W-1:0] ACT_ALLOC   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_SIZE    = 3'd1;
  localparam logic [ACT_W-1:0] ACT_HEIGHT  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_MOVE    = 3'd3;
  localparam logic [ACT_W-1:0] ACT_REFRESH = 3'd4;
  localparam logic [ACT_W-1:0] ACT_RELEASE = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_W = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_H = 2'd1;

  localparam logic [SIZE_W-1:0] SCREEN_W_RESET = 11'd320;
  localparam logic [SIZE_W-1:0] SCREEN_H_RESET = 11'd200;

  typedef logic signed [AREA_W-1:0] area_t;

  typedef struct packed {
    area_t x0;
    area_t y0;
    area_t x1;
    area_t y1;
  } rect_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [SIZE_W-1:0]         w;
    logic [SIZE_W-1:0]         h;
    logic [KEY_W-1:0]          key;
  } attr_t;

  typedef struct packed {
    logic                      kind;
    logic [ID_W-1:0]           out_layer;
    logic                      ok;
    logic [SIZE_W-1:0]         src_x0;
    logic [SIZE_W-1:0]         src_y0;
    logic [SIZE_W-1:0]         src_x1;
    logic [SIZE_W-1:0]         src_y1;
    logic signed [COORD_W-1:0] dst_x;
    logic signed [COORD_W-1:0] dst_y;
    logic [KEY_W-1:0]          key_out;
    logic                      last;
  } res_t;

  typedef struct packed {
    logic push;
    logic flush;
    res_t res;
  } q_ctl_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ATTR,
    S_ALLOC,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_RESTACK,
    S_SH_RD,
    S_SH_WR,
    S_SH_PUT,
    S_RP_LOAD,
    S_RP_INIT,
    S_RP_SO,
    S_RP_AT,
    S_RP_CALC,
    S_RP_END,
    S_FLUSH
  } state_t;

endpackage

// File: src/lsd_ifs.sv
// lsd_ifs: handshake channels of the scheduler (command, result, config).
// Depends on lsd_pkg.
interface lsd_cmd_if;
  import lsd_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [ACT_W-1:0]          action;
  logic [ID_W-1:0]           layer_id;
  logic signed [HREQ_W-1:0]  req_height;
  logic signed [COORD_W-1:0] x_a;
  logic signed [COORD_W-1:0] y_a;
  logic signed [COORD_W-1:0] x_b;
  logic signed [COORD_W-1:0] y_b;
  logic [SIZE_W-1:0]         size_x;
  logic [SIZE_W-1:0]         size_y;
  logic [KEY_W-1:0]          key_color;
  modport source (output valid, action, layer_id, req_height, x_a, y_a, x_b, y_b,
                  size_x, size_y, key_color, input ready);
  modport sink (input valid, action, layer_id, req_height, x_a, y_a, x_b, y_b,
                size_x, size_y, key_color, output ready);
endinterface

interface lsd_res_if;
  import lsd_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic [ID_W-1:0]           out_layer;
  logic                      ok;
  logic [SIZE_W-1:0]         src_x0;
  logic [SIZE_W-1:0]         src_y0;
  logic [SIZE_W-1:0]         src_x1;
  logic [SIZE_W-1:0]         src_y1;
  logic signed [COORD_W-1:0] dst_x;
  logic signed [COORD_W-1:0] dst_y;
  logic [KEY_W-1:0]          key_out;
  logic                      last;
  modport source (output valid, kind, out_layer, ok, src_x0, src_y0, src_x1, src_y1,
                  dst_x, dst_y, key_out, last, input ready);
  modport sink (input valid, kind, out_layer, ok, src_x0, src_y0, src_x1, src_y1,
                dst_x, dst_y, key_out, last, output ready);
endinterface

interface lsd_cfg_if;
  import lsd_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [SIZE_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: src/lsd_clip_unit.sv
// lsd_clip_unit: clips a screen area against one layer and forms its blit word.
// Depends on lsd_pkg.
module lsd_clip_unit (
  input  lsd_pkg::rect_t           area,
  input  lsd_pkg::attr_t           at,
  input  logic [lsd_pkg::ID_W-1:0] layer,
  output logic                     hit,
  output lsd_pkg::res_t            res
);
  import lsd_pkg::*;

  area_t ex, ey, ew, eh;
  area_t bx0, by0, bx1, by1;
  area_t rx0, ry0, rx1, ry1;
  area_t dx, dy;

  always_comb begin
    ex  = AREA_W'(at.x);
    ey  = AREA_W'(at.y);
    ew  = AREA_W'({1'b0, at.w});
    eh  = AREA_W'({1'b0, at.h});
    bx0 = area.x0 - ex;
    by0 = area.y0 - ey;
    bx1 = area.x1 - ex;
    by1 = area.y1 - ey;
    rx0 = (bx0 < 0) ? '0 : bx0;
    ry0 = (by0 < 0) ? '0 : by0;
    rx1 = (bx1 > ew) ? ew : bx1;
    ry1 = (by1 > eh) ? eh : by1;
    dx  = ex + rx0;
    dy  = ey + ry0;
    hit = (rx0 < rx1) && (ry0 < ry1);
    res.kind      = 1'b1;
    res.out_layer = layer;
    res.ok        = 1'b1;
    res.src_x0    = rx0[SIZE_W-1:0];
    res.src_y0    = ry0[SIZE_W-1:0];
    res.src_x1    = rx1[SIZE_W-1:0];
    res.src_y1    = ry1[SIZE_W-1:0];
    res.dst_x     = dx[COORD_W-1:0];
    res.dst_y     = dy[COORD_W-1:0];
    res.key_out   = at.key;
    res.last      = 1'b0;
  end
endmodule

// File: src/lsd_result_queue.sv
// lsd_result_queue: one-word hold stage that marks the final word of a command,
// followed by the output register. Depends on lsd_pkg and lsd_ifs.
module lsd_result_queue (
  input  logic            clk,
  input  logic            rst,
  input  lsd_pkg::q_ctl_t ctl,
  output logic            q_rdy,
  lsd_res_if.source       res
);
  import lsd_pkg::*;

  logic hold_v, out_v;
  res_t hold, out_w;
  logic out_free;

  assign out_free = !out_v || res.ready;
  assign q_rdy    = !hold_v || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_v <= 1'b0;
      out_v  <= 1'b0;
    end else begin
      if (out_v && res.ready) begin
        out_v <= 1'b0;
      end
      if (ctl.push && q_rdy) begin
        if (hold_v) begin
          out_v <= 1'b1;
        end
        hold_v <= 1'b1;
      end else if (ctl.flush && q_rdy && hold_v) begin
        out_v  <= 1'b1;
        hold_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push && q_rdy) begin
      if (hold_v) begin
        out_w <= hold;
      end
      hold <= ctl.res;
    end else if (ctl.flush && q_rdy && hold_v) begin
      out_w      <= hold;
      out_w.last <= 1'b1;
    end
  end

  assign res.valid     = out_v;
  assign res.kind      = out_w.kind;
  assign res.out_layer = out_w.out_layer;
  assign res.ok        = out_w.ok;
  assign res.src_x0    = out_w.src_x0;
  assign res.src_y0    = out_w.src_y0;
  assign res.src_x1    = out_w.src_x1;
  assign res.src_y1    = out_w.src_y1;
  assign res.dst_x     = out_w.dst_x;
  assign res.dst_y     = out_w.dst_y;
  assign res.key_out   = out_w.key_out;
  assign res.last      = out_w.last;
endmodule

// File: src/lsd_engine.sv
// lsd_engine: command sequencer around the layer attribute memory and the
// stack order memory. Depends on lsd_pkg, lsd_ifs and lsd_clip_unit.
module lsd_engine #(
  parameter int NUM_LAYERS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  lsd_cmd_if.sink                    cmd,
  input  logic [lsd_pkg::SIZE_W-1:0] screen_w,
  input  logic [lsd_pkg::SIZE_W-1:0] screen_h,
  output lsd_pkg::q_ctl_t            q_ctl,
  input  logic                       q_rdy
);
  import lsd_pkg::*;

  localparam int LW  = $clog2(NUM_LAYERS);
  localparam int CW  = $clog2(NUM_LAYERS + 1);
  localparam int LVW = (CW + 1 > HREQ_W) ? CW + 1 : HREQ_W;
  localparam int IW  = (LW > ID_W) ? LW : ID_W;

  typedef logic signed [LVW-1:0] lvl_t;
  localparam lvl_t LVL_NONE = '1;

  state_t state, state_next;

  // memories
  attr_t         attr_mem [NUM_LAYERS];
  logic [LW-1:0] so_mem   [NUM_LAYERS];
  attr_t         attr_rd;
  logic [LW-1:0] so_rd;
  logic [LW-1:0] attr_raddr, so_raddr, so_waddr;
  logic [LW-1:0] so_wdata;
  logic          so_we;

  logic [NUM_LAYERS-1:0] used, shown;
  logic [CW-1:0]         cnt, hp;
  logic [NRES_W-1:0]     nres;

  logic [ACT_W-1:0]          c_act;
  logic [LW-1:0]             c_idx;
  lvl_t                      c_req;
  logic signed [COORD_W-1:0] c_xa, c_ya;
  attr_t                     cur;
  lvl_t                      old, tgt, ptr, lo, hi;
  logic                      up, put_id, second;
  rect_t                     area;

  logic          accept, id_ok;
  logic [IW-1:0] id_w;
  logic [LW-1:0] idx_in;

  // allocate search
  logic          free_found;
  logic [LW-1:0] free_idx;
  logic [IW-1:0] free_w;

  // restack plan
  lvl_t cnt_l, top, lim, hc, hgt, p_lo, p_hi;
  logic p_up, p_same, p_empty;

  // screen clip
  area_t sw_a, sh_a;
  rect_t ca;
  logic  ca_empty;

  // layer clip
  logic clip_hit, want;
  res_t clip_res;
  logic [IW-1:0] lay_w;

  logic sh_done;
  lvl_t hp_l;

  assign accept = cmd.valid && cmd.ready;
  assign id_w   = IW'(cmd.layer_id);
  assign idx_in = id_w[LW-1:0];
  assign id_ok  = (32'(cmd.layer_id) < NUM_LAYERS) && used[idx_in];
  assign cmd.ready = (state == S_IDLE);

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_LAYERS - 1; i >= 0; i--) begin
      if (!used[i]) begin
        free_found = 1'b1;
        free_idx   = LW'(i);
      end
    end
  end
  assign free_w = IW'(free_idx);

  // height clamp and shift range, from the old level and the request
  always_comb begin
    cnt_l  = LVW'(signed'({1'b0, cnt}));
    top    = cnt_l - lvl_t'(1);
    lim    = (old >= 0) ? top : cnt_l;
    hc     = (c_req > lim) ? lim : c_req;
    hgt    = (hc < LVL_NONE) ? LVL_NONE : hc;
    p_same = (old == hgt);
    p_up   = (hgt >= 0) && ((old > hgt) || (old == LVL_NONE));
    if (p_up) begin
      p_hi = (old == LVL_NONE) ? cnt_l : old;
      p_lo = hgt + lvl_t'(1);
    end else begin
      p_lo = old;
      p_hi = (hgt == LVL_NONE) ? top - lvl_t'(1) : hgt - lvl_t'(1);
    end
    p_empty = (p_hi < p_lo);
  end

  always_comb begin
    sw_a  = AREA_W'({1'b0, screen_w});
    sh_a  = AREA_W'({1'b0, screen_h});
    ca.x0 = (area.x0 < 0) ? '0 : area.x0;
    ca.y0 = (area.y0 < 0) ? '0 : area.y0;
    ca.x1 = (area.x1 > sw_a) ? sw_a : area.x1;
    ca.y1 = (area.y1 > sh_a) ? sh_a : area.y1;
    ca_empty = (ca.x0 >= ca.x1) || (ca.y0 >= ca.y1);
  end

  assign lay_w = IW'(so_rd);

  lsd_clip_unit u_clip (
    .area  (area),
    .at    (attr_rd),
    .layer (lay_w[ID_W-1:0]),
    .hit   (clip_hit),
    .res   (clip_res)
  );

  assign want    = clip_hit && (nres < NRES_W'(MAX_RESULTS));
  assign sh_done = up ? (ptr == lo) : (ptr == hi);
  assign hp_l    = LVW'(signed'({1'b0, hp}));

  always_comb begin
    state_next = state;
    attr_raddr = idx_in;
    so_raddr   = hp[LW-1:0];
    so_we      = 1'b0;
    so_waddr   = ptr[LW-1:0];
    so_wdata   = so_rd;
    q_ctl      = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (cmd.action)
            ACT_ALLOC:   state_next = S_ALLOC;
            ACT_REFRESH: state_next = S_RP_INIT;
            ACT_HEIGHT, ACT_MOVE, ACT_RELEASE: state_next = id_ok ? S_ATTR : S_FLUSH;
            default:     state_next = S_FLUSH;
          endcase
        end
      end
      S_ATTR: begin
        unique case (c_act)
          ACT_MOVE:   state_next = shown[c_idx] ? S_RP_LOAD : S_FLUSH;
          ACT_HEIGHT: state_next = shown[c_idx] ? S_SRCH_RD : S_RESTACK;
          default:    state_next = shown[c_idx] ? S_SRCH_RD : S_FLUSH;
        endcase
      end
      S_ALLOC: begin
        q_ctl.push          = q_rdy;
        q_ctl.res.ok        = free_found;
        q_ctl.res.out_layer = free_w[ID_W-1:0];
        if (q_rdy) begin
          state_next = S_FLUSH;
        end
      end
      S_SRCH_RD: state_next = S_SRCH_CMP;
      S_SRCH_CMP: begin
        if (so_rd == c_idx || hp == cnt - 1'b1) begin
          state_next = S_RESTACK;
        end else begin
          state_next = S_SRCH_RD;
        end
      end
      S_RESTACK: begin
        if (p_same) begin
          state_next = S_FLUSH;
        end else if (p_empty) begin
          state_next = (hgt != LVL_NONE) ? S_SH_PUT : S_RP_LOAD;
        end else begin
          state_next = S_SH_RD;
        end
      end
      S_SH_RD: begin
        so_raddr   = up ? LW'(ptr - lvl_t'(1)) : LW'(ptr + lvl_t'(1));
        state_next = S_SH_WR;
      end
      S_SH_WR: begin
        so_we = 1'b1;
        if (sh_done) begin
          state_next = put_id ? S_SH_PUT : S_RP_LOAD;
        end else begin
          state_next = S_SH_RD;
        end
      end
      S_SH_PUT: begin
        so_we      = 1'b1;
        so_waddr   = tgt[LW-1:0];
        so_wdata   = c_idx;
        state_next = S_RP_LOAD;
      end
      S_RP_LOAD: state_next = S_RP_INIT;
      S_RP_INIT: state_next = ca_empty ? S_RP_END : S_RP_SO;
      S_RP_SO:   state_next = (hp >= cnt) ? S_RP_END : S_RP_AT;
      S_RP_AT: begin
        attr_raddr = so_rd;
        state_next = S_RP_CALC;
      end
      S_RP_CALC: begin
        q_ctl.res  = clip_res;
        q_ctl.push = want && q_rdy;
        if (!want || q_rdy) begin
          state_next = S_RP_SO;
        end
      end
      S_RP_END:  state_next = second ? S_RP_INIT : S_FLUSH;
      S_FLUSH: begin
        q_ctl.flush = 1'b1;
        if (q_rdy) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept && cmd.action == ACT_SIZE && id_ok) begin
      attr_mem[idx_in].w   <= cmd.size_x;
      attr_mem[idx_in].h   <= cmd.size_y;
      attr_mem[idx_in].key <= cmd.key_color;
    end
    if (state == S_ATTR && c_act == ACT_MOVE) begin
      attr_mem[c_idx].x <= c_xa;
      attr_mem[c_idx].y <= c_ya;
    end
    attr_rd <= attr_mem[attr_raddr];
  end

  always_ff @(posedge clk) begin
    if (so_we) begin
      so_mem[so_waddr] <= so_wdata;
    end
    so_rd <= so_mem[so_raddr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      used  <= '0;
      shown <= '0;
      cnt   <= '0;
      nres  <= '0;
    end else begin
      if (accept) begin
        nres <= '0;
        if (cmd.action == ACT_RELEASE && id_ok) begin
          used[idx_in] <= 1'b0;
        end
      end
      if (q_ctl.push) begin
        nres <= nres + 1'b1;
      end
      if (state == S_ALLOC && q_rdy && free_found) begin
        used[free_idx]  <= 1'b1;
        shown[free_idx] <= 1'b0;
      end
      if (state == S_RESTACK && !p_same) begin
        if (old == LVL_NONE) begin
          shown[c_idx] <= 1'b1;
          cnt          <= cnt + 1'b1;
        end else if (hgt == LVL_NONE) begin
          shown[c_idx] <= 1'b0;
          cnt          <= cnt - 1'b1;
        end
      end
    end
  end

  // working registers of the current command
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        c_act  <= cmd.action;
        c_idx  <= idx_in;
        c_req  <= (cmd.action == ACT_RELEASE) ? LVL_NONE : LVW'(cmd.req_height);
        c_xa   <= cmd.x_a;
        c_ya   <= cmd.y_a;
        second <= 1'b0;
        hp     <= '0;
        area.x0 <= AREA_W'(cmd.x_a);
        area.y0 <= AREA_W'(cmd.y_a);
        area.x1 <= AREA_W'(cmd.x_b);
        area.y1 <= AREA_W'(cmd.y_b);
      end
      S_ATTR: begin
        cur    <= attr_rd;
        old    <= LVL_NONE;
        second <= (c_act == ACT_MOVE);
      end
      S_SRCH_CMP: begin
        if (so_rd == c_idx || hp == cnt - 1'b1) begin
          old <= hp_l;
        end else begin
          hp <= hp + 1'b1;
        end
      end
      S_RESTACK: begin
        tgt    <= hgt;
        up     <= p_up;
        put_id <= (hgt != LVL_NONE);
        lo     <= p_lo;
        hi     <= p_hi;
        ptr    <= p_up ? p_hi : p_lo;
      end
      S_SH_WR: begin
        if (!sh_done) begin
          ptr <= up ? (ptr - lvl_t'(1)) : (ptr + lvl_t'(1));
        end
      end
      S_RP_LOAD: begin
        area.x0 <= AREA_W'(cur.x);
        area.y0 <= AREA_W'(cur.y);
        area.x1 <= AREA_W'(cur.x) + AREA_W'({1'b0, cur.w});
        area.y1 <= AREA_W'(cur.y) + AREA_W'({1'b0, cur.h});
      end
      S_RP_INIT: begin
        area <= ca;
        hp   <= '0;
      end
      S_RP_CALC: begin
        if (!want || q_rdy) begin
          hp <= hp + 1'b1;
        end
      end
      S_RP_END: begin
        // move: second pass over the new rectangle
        second  <= 1'b0;
        area.x0 <= AREA_W'(c_xa);
        area.y0 <= AREA_W'(c_ya);
        area.x1 <= AREA_W'(c_xa) + AREA_W'({1'b0, cur.w});
        area.y1 <= AREA_W'(c_ya) + AREA_W'({1'b0, cur.h});
      end
      default: begin
      end
    endcase
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    32'(cnt) <= NUM_LAYERS)
    else $error("shown count beyond layer count");

  a_cnt_match: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> $countones(shown) == 32'(cnt))
    else $error("shown flags disagree with shown count");

  a_res_cap: assert property (@(posedge clk) disable iff (rst)
    q_ctl.push |-> nres < NRES_W'(MAX_RESULTS))
    else $error("result pushed past the per-command cap");

  a_one_op: assert property (@(posedge clk) disable iff (rst)
    !(q_ctl.push && q_ctl.flush))
    else $error("push and flush in the same cycle");
endmodule

// File: src/layer_stack_damage_scheduler_unit.sv
// layer_stack_damage_scheduler_unit: top level, screen size registers and
// wiring. Depends on lsd_pkg, lsd_ifs, lsd_engine and lsd_result_queue.
//
// Usage: commands arrive on cmd (valid/ready), one word each: allocate, set
// size and key, set height, move, refresh area, release. Each command returns
// zero or more words on res; the final word of a command carries last. An
// allocate gives one reply word; height changes, releases and moves of shown
// layers and refreshes give one blit word per shown layer whose clipped part
// is not empty, bottom to top, at most 32 per command. cfg writes screen width
// (index 0) and screen height (index 1); it is always ready; the user must
// write it only while idle, as the block itself does not enforce this.
// Timing: cmd takes one command at a time. A command runs through setup, a
// search and shift of stack entries, and a pass over the shown layers for each
// repainted area; the stack order memory, with one access per cycle, sets the
// pace. A word leaves the hold stage only when the next word or the end of the
// command arrives. A stalled res holds its word; the engine keeps working until
// the hold stage and output register are both full.
// Reset: all layers free, none shown, screen 320 x 200; no clearing pass.
module layer_stack_damage_scheduler_unit #(
  parameter int NUM_LAYERS = 16
) (
  input  logic      clk,
  input  logic      rst,
  lsd_cfg_if.sink   cfg,
  lsd_cmd_if.sink   cmd,
  lsd_res_if.source res
);
  import lsd_pkg::*;

  logic [SIZE_W-1:0] screen_w, screen_h;
  q_ctl_t            q_ctl;
  logic              q_rdy;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_w <= SCREEN_W_RESET;
      screen_h <= SCREEN_H_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        CFG_SCREEN_W: screen_w <= cfg.data;
        CFG_SCREEN_H: screen_h <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  lsd_engine #(
    .NUM_LAYERS (NUM_LAYERS)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .screen_w (screen_w),
    .screen_h (screen_h),
    .q_ctl    (q_ctl),
    .q_rdy    (q_rdy)
  );

  lsd_result_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .ctl   (q_ctl),
    .q_rdy (q_rdy),
    .res   (res)
  );
endmodule

// File: verif/layer_stack_damage_scheduler_unit_tb.sv
// layer_stack_damage_scheduler_unit_tb: self-checking bench for the layer stack
// scheduler; a scoreboard class predicts every result word. Depends on lsd_pkg,
// lsd_ifs and the scheduler RTL.
`timescale 1ns / 1ps

module layer_stack_damage_scheduler_unit_tb;
  import lsd_pkg::*;

  localparam int NL = 16;
  localparam int TIMEOUT_CYCLES = 2000000;
  localparam int SETTLE_CYCLES = 200;

  typedef struct packed {
    logic [ACT_W-1:0]          action;
    logic [ID_W-1:0]           layer_id;
    logic signed [HREQ_W-1:0]  req_height;
    logic signed [COORD_W-1:0] x_a;
    logic signed [COORD_W-1:0] y_a;
    logic signed [COORD_W-1:0] x_b;
    logic signed [COORD_W-1:0] y_b;
    logic [SIZE_W-1:0]         size_x;
    logic [SIZE_W-1:0]         size_y;
    logic [KEY_W-1:0]          key_color;
  } cmd_word_t;

  class layer_scoreboard;
    int scr_w, scr_h;
    bit used[NL];
    bit size_known[NL];
    bit pos_known[NL];
    int level[NL], lx[NL], ly[NL], lw[NL], lh[NL], key[NL], order[NL];
    int shown;
    res_t pending_words[$];
    res_t burst[$];
    int errors;
    int words_seen;
    int blits_seen;

    function new();
      scr_w = SCREEN_W_RESET;
      scr_h = SCREEN_H_RESET;
      shown = 0;
      errors = 0;
      words_seen = 0;
      blits_seen = 0;
      for (int i = 0; i < NL; i++) begin
        used[i] = 0; size_known[i] = 0; pos_known[i] = 0;
        level[i] = 0; lx[i] = 0; ly[i] = 0; lw[i] = 0; lh[i] = 0;
        key[i] = 0; order[i] = 0;
      end
    endfunction

    function void set_screen(logic [CFG_IDX_W-1:0] idx, int val);
      if (idx == CFG_SCREEN_W) scr_w = val;
      else if (idx == CFG_SCREEN_H) scr_h = val;
    endfunction

    // commands on a live layer must not read entries that were never written
    function bit legal(cmd_word_t c);
      if (c.layer_id >= NL || !used[c.layer_id]) return 1;
      if (c.action == ACT_HEIGHT || c.action == ACT_RELEASE)
        return size_known[c.layer_id] && pos_known[c.layer_id];
      if (c.action == ACT_MOVE) return size_known[c.layer_id];
      return 1;
    endfunction

    function void emit(logic k, int id, logic okv, int sx0, int sy0, int sx1, int sy1,
                       int dx, int dy, int kc);
      res_t r;
      if (burst.size() >= MAX_RESULTS) return;
      r.kind = k; r.out_layer = ID_W'(id); r.ok = okv;
      r.src_x0 = SIZE_W'(sx0); r.src_y0 = SIZE_W'(sy0);
      r.src_x1 = SIZE_W'(sx1); r.src_y1 = SIZE_W'(sy1);
      r.dst_x = COORD_W'(dx); r.dst_y = COORD_W'(dy); r.key_out = KEY_W'(kc);
      r.last = 0;
      burst.push_back(r);
    endfunction

    function void paint_area(int ax0, int ay0, int ax1, int ay1);
      int id, bx0, by0, bx1, by1;
      if (ax0 < 0) ax0 = 0;
      if (ay0 < 0) ay0 = 0;
      if (ax1 > scr_w) ax1 = scr_w;
      if (ay1 > scr_h) ay1 = scr_h;
      if (ax0 >= ax1 || ay0 >= ay1) return;
      for (int h = 0; h < shown && h < NL; h++) begin
        id = order[h];
        bx0 = ax0 - lx[id]; by0 = ay0 - ly[id];
        bx1 = ax1 - lx[id]; by1 = ay1 - ly[id];
        if (bx0 < 0) bx0 = 0;
        if (by0 < 0) by0 = 0;
        if (bx1 > lw[id]) bx1 = lw[id];
        if (by1 > lh[id]) by1 = lh[id];
        if (bx0 < bx1 && by0 < by1)
          emit(1'b1, id, 1'b1, bx0, by0, bx1, by1, lx[id] + bx0, ly[id] + by0, key[id]);
      end
    endfunction

    function void change_level(int id, int hgt);
      int old, top, lim;
      old = level[id];
      top = shown - 1;
      lim = (old >= 0) ? top : top + 1;
      if (hgt > lim) hgt = lim;
      if (hgt < -1) hgt = -1;
      if (old == hgt) return;
      level[id] = hgt;
      if (old > hgt) begin
        if (hgt >= 0) begin
          for (int h = old; h > hgt; h--) begin
            order[h] = order[h-1]; level[order[h]] = h;
          end
          order[hgt] = id;
        end else begin
          for (int h = old; h < top; h++) begin
            order[h] = order[h+1]; level[order[h]] = h;
          end
          shown--;
        end
      end else begin
        if (old >= 0) begin
          for (int h = old; h < hgt; h++) begin
            order[h] = order[h+1]; level[order[h]] = h;
          end
          order[hgt] = id;
        end else begin
          for (int h = top; h >= hgt; h--) begin
            order[h+1] = order[h]; level[order[h+1]] = h + 1;
          end
          order[hgt] = id;
          shown++;
        end
      end
      paint_area(lx[id], ly[id], lx[id] + lw[id], ly[id] + lh[id]);
    endfunction

    function void note_cmd(cmd_word_t c);
      int id, ox, oy, xa, ya;
      bit found;
      res_t r;
      id = c.layer_id;
      xa = $signed(c.x_a);
      ya = $signed(c.y_a);
      burst.delete();
      if (c.action == ACT_ALLOC) begin
        found = 0;
        for (int i = 0; i < NL && !found; i++) begin
          if (!used[i]) begin
            used[i] = 1; level[i] = -1; found = 1;
            emit(1'b0, i, 1'b1, 0, 0, 0, 0, 0, 0, 0);
          end
        end
        if (!found) emit(1'b0, 0, 1'b0, 0, 0, 0, 0, 0, 0, 0);
      end else if (c.action == ACT_REFRESH) begin
        paint_area(xa, ya, $signed(c.x_b), $signed(c.y_b));
      end else if (id < NL && used[id]) begin
        case (c.action)
          ACT_SIZE: begin
            lw[id] = c.size_x; lh[id] = c.size_y; key[id] = c.key_color;
            size_known[id] = 1;
          end
          ACT_HEIGHT: change_level(id, $signed(c.req_height));
          ACT_MOVE: begin
            ox = lx[id]; oy = ly[id];
            lx[id] = xa; ly[id] = ya; pos_known[id] = 1;
            if (level[id] >= 0) begin
              paint_area(ox, oy, ox + lw[id], oy + lh[id]);
              paint_area(xa, ya, xa + lw[id], ya + lh[id]);
            end
          end
          ACT_RELEASE: begin
            if (level[id] >= 0) change_level(id, -1);
            used[id] = 0;
          end
          default: ;
        endcase
      end
      if (burst.size() > 0) begin
        r = burst.pop_back();
        r.last = 1;
        burst.push_back(r);
      end
      foreach (burst[i]) pending_words.push_back(burst[i]);
    endfunction

    function int field_diff(string name, logic [31:0] e, logic [31:0] g);
      if (e !== g) begin
        $display("%0t mismatch %s: expected %0h actual %0h", $time, name, e, g);
        return 1;
      end
      return 0;
    endfunction

    function void check_word(res_t g);
      res_t e;
      int bad;
      words_seen++;
      if (pending_words.size() == 0) begin
        $display("%0t unexpected word: expected none actual %h", $time, g);
        errors++;
        return;
      end
      e = pending_words.pop_front();
      if (e.kind) blits_seen++;
      bad = 0;
      bad += field_diff("kind", e.kind, g.kind);
      bad += field_diff("out_layer", e.out_layer, g.out_layer);
      bad += field_diff("ok", e.ok, g.ok);
      bad += field_diff("src_x0", e.src_x0, g.src_x0);
      bad += field_diff("src_y0", e.src_y0, g.src_y0);
      bad += field_diff("src_x1", e.src_x1, g.src_x1);
      bad += field_diff("src_y1", e.src_y1, g.src_y1);
      bad += field_diff("dst_x", e.dst_x, g.dst_x);
      bad += field_diff("dst_y", e.dst_y, g.dst_y);
      bad += field_diff("key_out", e.key_out, g.key_out);
      bad += field_diff("last", e.last, g.last);
      if (bad != 0) errors++;
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  lsd_cfg_if cfg ();
  lsd_cmd_if cmd ();
  lsd_res_if res ();

  layer_stack_damage_scheduler_unit #(.NUM_LAYERS(NL)) DUT (
    .clk(clk), .rst(rst), .cfg(cfg.sink), .cmd(cmd.sink), .res(res.source)
  );

  layer_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_len = 0;
  int cycles = 0;
  int cmds_sent = 0;

  always #5 clk = ~clk;

  initial begin
    cmd.valid = 0; cmd.action = '0; cmd.layer_id = '0; cmd.req_height = '0;
    cmd.x_a = '0; cmd.y_a = '0; cmd.x_b = '0; cmd.y_b = '0;
    cmd.size_x = '0; cmd.size_y = '0; cmd.key_color = '0;
    cfg.valid = 0; cfg.index = '0; cfg.data = '0;
    res.ready = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > TIMEOUT_CYCLES) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles,
               sb.pending_words.size());
      $display("FAIL layer_stack_damage_scheduler_unit");
      $finish;
    end
  end

  // result side: check accepted words, then pick next ready
  always @(posedge clk) begin
    res_t g;
    if (!rst && res.valid && res.ready) begin
      g.kind = res.kind; g.out_layer = res.out_layer; g.ok = res.ok;
      g.src_x0 = res.src_x0; g.src_y0 = res.src_y0;
      g.src_x1 = res.src_x1; g.src_y1 = res.src_y1;
      g.dst_x = res.dst_x; g.dst_y = res.dst_y; g.key_out = res.key_out;
      g.last = res.last;
      sb.check_word(g);
    end
    if (hold_len > 0) begin
      hold_len = hold_len - 1;
      res.ready <= 1'b0;
    end else begin
      res.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic push_cmd(cmd_word_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd.valid <= 1'b0;
      @(posedge clk);
    end
    cmd.valid <= 1'b1;
    cmd.action <= c.action; cmd.layer_id <= c.layer_id; cmd.req_height <= c.req_height;
    cmd.x_a <= c.x_a; cmd.y_a <= c.y_a; cmd.x_b <= c.x_b; cmd.y_b <= c.y_b;
    cmd.size_x <= c.size_x; cmd.size_y <= c.size_y; cmd.key_color <= c.key_color;
    do @(posedge clk); while (!cmd.ready);
    sb.note_cmd(c);
    cmds_sent++;
  endtask

  task automatic drain_results();
    cmd.valid <= 1'b0;
    while (sb.pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_screen(logic [CFG_IDX_W-1:0] idx, int val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= SIZE_W'(val);
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    sb.set_screen(idx, val);
    @(posedge clk);
  endtask

  function automatic cmd_word_t mk(logic [ACT_W-1:0] a, int id, int hq, int xa, int ya,
                                   int xb, int yb, int sx, int sy, int kc);
    cmd_word_t c;
    c.action = a; c.layer_id = ID_W'(id); c.req_height = HREQ_W'(hq);
    c.x_a = COORD_W'(xa); c.y_a = COORD_W'(ya);
    c.x_b = COORD_W'(xb); c.y_b = COORD_W'(yb);
    c.size_x = SIZE_W'(sx); c.size_y = SIZE_W'(sy); c.key_color = KEY_W'(kc);
    return c;
  endfunction

  function automatic int pick_coord(int span);
    if ($urandom_range(9) == 0) return $signed(12'($urandom()));
    return $urandom_range(span + 100) - 100;
  endfunction

  function automatic cmd_word_t rand_cmd();
    cmd_word_t c;
    int r, live[$];
    logic [95:0] rbits;
    rbits = {$urandom(), $urandom(), $urandom()};
    c = rbits[$bits(cmd_word_t)-1:0];
    r = $urandom_range(99);
    if (r < 14) c.action = ACT_ALLOC;
    else if (r < 28) c.action = ACT_SIZE;
    else if (r < 52) c.action = ACT_HEIGHT;
    else if (r < 72) c.action = ACT_MOVE;
    else if (r < 88) c.action = ACT_REFRESH;
    else if (r < 96) c.action = ACT_RELEASE;
    else c.action = 3'($urandom_range(7, 6));
    for (int i = 0; i < NL; i++) if (sb.used[i]) live.push_back(i);
    if (live.size() > 0 && $urandom_range(9) < 8)
      c.layer_id = ID_W'(live[$urandom_range(live.size() - 1)]);
    if ($urandom_range(9) < 8) c.req_height = HREQ_W'($urandom_range(16) - 1);
    if ($urandom_range(9) < 8) begin
      c.size_x = SIZE_W'($urandom_range(300));
      c.size_y = SIZE_W'($urandom_range(200));
    end
    c.x_a = COORD_W'(pick_coord(sb.scr_w));
    c.y_a = COORD_W'(pick_coord(sb.scr_h));
    c.x_b = COORD_W'(pick_coord(sb.scr_w));
    c.y_b = COORD_W'(pick_coord(sb.scr_h));
    if (!sb.legal(c)) c.action = ACT_REFRESH;
    return c;
  endfunction

  task automatic run_directed();
    for (int i = 0; i < 3; i++) push_cmd(mk(ACT_ALLOC, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    push_cmd(mk(ACT_SIZE, 0, 0, 0, 0, 0, 0, 100, 80, 8'h00));
    push_cmd(mk(ACT_SIZE, 1, 0, 0, 0, 0, 0, 2047, 2047, 8'hff));
    push_cmd(mk(ACT_SIZE, 2, 0, 0, 0, 0, 0, 50, 50, 8'h5a));
    push_cmd(mk(ACT_MOVE, 0, 0, 10, 20, 0, 0, 0, 0, 0));
    push_cmd(mk(ACT_MOVE, 1, 0, -2048, -2048, 0, 0, 0, 0, 0));
    push_cmd(mk(ACT_MOVE, 2, 0, 2047, 2047, 0, 0, 0, 0, 0));
    push_cmd(mk(ACT_HEIGHT, 0, 15, 0, 0, 0, 0, 0, 0, 0));       // clamp to count
    push_cmd(mk(ACT_HEIGHT, 1, 0, 0, 0, 0, 0, 0, 0, 0));
    push_cmd(mk(ACT_HEIGHT, 2, 1, 0, 0, 0, 0, 0, 0, 0));
    push_cmd(mk(ACT_HEIGHT, 2, 1, 0, 0, 0, 0, 0, 0, 0));        // unchanged height
    push_cmd(mk(ACT_REFRESH, 9, 0, -2048, -2048, 2047, 2047, 0, 0, 0));
    push_cmd(mk(ACT_REFRESH, 0, 0, 50, 50, 50, 90, 0, 0, 0));    // empty area
    push_cmd(mk(ACT_MOVE, 2, 0, 300, 180, 0, 0, 0, 0, 0));       // shown layer move
    push_cmd(mk(ACT_HEIGHT, 0, -16, 0, 0, 0, 0, 0, 0, 0));       // below -1 hides
    push_cmd(mk(ACT_MOVE, 0, 0, -5, -5, 0, 0, 0, 0, 0));         // hidden layer move
    push_cmd(mk(ACT_HEIGHT, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    push_cmd(mk(ACT_RELEASE, 1, 0, 0, 0, 0, 0, 0, 0, 0));        // release shown
    push_cmd(mk(ACT_RELEASE, 15, 0, 0, 0, 0, 0, 0, 0, 0));       // unused layer
    push_cmd(mk(ACT_HEIGHT, 14, 3, 0, 0, 0, 0, 0, 0, 0));
    push_cmd(mk(3'd6, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    push_cmd(mk(3'd7, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    drain_results();
  endtask

  initial begin
    int sw[5] = '{2047, 1, 2047, 640, 320};
    int sh[5] = '{1, 2047, 2047, 480, 200};
    int snd[5] = '{10, 85, 0, 0, 10};
    int rcv[5] = '{85, 10, 0, 0, 0};
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    for (int seg = 0; seg < 5; seg++) begin
      write_screen(CFG_SCREEN_W, sw[seg]);
      write_screen(CFG_SCREEN_H, sh[seg]);
      send_idle_pct = snd[seg];
      recv_idle_pct = rcv[seg];
      if (seg == 3) hold_len = 600;   // long receiver stall while words keep coming
      for (int n = 0; n < 90; n++) push_cmd(rand_cmd());
      drain_results();
    end
    $display("%0d commands, %0d result words (%0d blits) over five screen sizes",
             cmds_sent, sb.words_seen, sb.blits_seen);
    if (sb.errors == 0 && sb.pending_words.size() == 0) begin
      $display("PASS layer_stack_damage_scheduler_unit");
    end else begin
      $display("FAIL layer_stack_damage_scheduler_unit");
    end
    $finish;
  end

endmodule
